>>> rtl/core/mh2_pkg.sv
// shared types and constants for the murmurhash2 block
`timescale 1ns / 1ps
package mh2_pkg;

  localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
  localparam logic [31:0] SEED_RESET = 32'd2928213749;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // operations passed from front to back
  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_WORD = 2'd1;
  localparam logic [1:0] OP_TAIL = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic        fin;
    logic [31:0] value;
  } mh2_op_t;

endpackage

>>> rtl/core/mh2_front.sv
// front end: takes items, gathers bytes into words, issues hash operations
`timescale 1ns / 1ps
module mh2_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [31:0]     cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            kind,
  input  logic [31:0]     message_length,
  input  logic [7:0]      data_byte,
  output logic            op_valid,
  input  logic            op_ready,
  output mh2_pkg::mh2_op_t op_data
);
  import mh2_pkg::*;

  logic [31:0] seed;
  logic [23:0] partial_word;
  logic [1:0]  byte_position;
  logic [31:0] bytes_remaining;
  logic        message_active;

  logic        accept;
  logic        last_byte;
  logic [31:0] word_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = op_ready;
  assign accept    = in_valid && in_ready;
  assign last_byte = (bytes_remaining == 32'd1);

  always_comb begin
    case (byte_position)
      2'd0:    word_next = {24'd0, data_byte};
      2'd1:    word_next = {16'd0, data_byte, partial_word[7:0]};
      2'd2:    word_next = {8'd0, data_byte, partial_word[15:0]};
      default: word_next = {data_byte, partial_word};
    endcase
  end

  always_comb begin
    op_valid      = 1'b0;
    op_data.op    = OP_INIT;
    op_data.fin   = 1'b0;
    op_data.value = word_next;
    if (in_valid) begin
      if (!kind) begin
        op_valid      = 1'b1;
        op_data.op    = OP_INIT;
        op_data.fin   = (message_length == 32'd0);
        op_data.value = seed ^ message_length;
      end else if (message_active) begin
        if (byte_position == 2'd3) begin
          op_valid    = 1'b1;
          op_data.op  = OP_WORD;
          op_data.fin = last_byte;
        end else if (last_byte) begin
          op_valid    = 1'b1;
          op_data.op  = OP_TAIL;
          op_data.fin = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed            <= SEED_RESET;
      partial_word    <= '0;
      byte_position   <= '0;
      bytes_remaining <= '0;
      message_active  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed <= cfg_data;
      end
      if (accept) begin
        if (!kind) begin
          partial_word    <= '0;
          byte_position   <= '0;
          bytes_remaining <= message_length;
          message_active  <= (message_length != 32'd0);
        end else if (message_active) begin
          bytes_remaining <= bytes_remaining - 32'd1;
          if (byte_position == 2'd3 || last_byte) begin
            partial_word  <= '0;
            byte_position <= '0;
          end else begin
            partial_word  <= word_next[23:0];
            byte_position <= byte_position + 2'd1;
          end
          if (last_byte) begin
            message_active <= 1'b0;
          end
        end
      end
    end
  end

endmodule

>>> rtl/core/mh2_queue.sv
// small fifo of hash operations between front and back
`timescale 1ns / 1ps
module mh2_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  mh2_pkg::mh2_op_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output mh2_pkg::mh2_op_t pop_data
);
  import mh2_pkg::*;

  mh2_op_t             entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/mh2_back.sv
// back end: runs hash operations on one shared multiplier and holds the result
`timescale 1ns / 1ps
module mh2_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_valid,
  output logic             op_ready,
  input  mh2_pkg::mh2_op_t op_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      hash_value
);
  import mh2_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_K1   = 3'd1;
  localparam logic [2:0] S_K2   = 3'd2;
  localparam logic [2:0] S_H    = 3'd3;
  localparam logic [2:0] S_T    = 3'd4;
  localparam logic [2:0] S_F1   = 3'd5;
  localparam logic [2:0] S_F2   = 3'd6;

  logic [2:0]  state;
  logic [31:0] acc;
  logic [31:0] kreg;
  logic        fin;
  logic [31:0] mul_a;
  logic [31:0] prod;
  logic        out_free;
  logic        out_load;

  assign op_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign out_load = (state == S_F2) && out_free;
  assign prod     = mul_a * MIX_MUL;

  always_comb begin
    unique case (state)
      S_K1:    mul_a = kreg;
      S_K2:    mul_a = kreg ^ (kreg >> 24);
      S_T:     mul_a = acc ^ kreg;
      S_F1:    mul_a = acc ^ (acc >> 13);
      default: mul_a = acc;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      hash_value <= acc ^ (acc >> 15);
      out_valid  <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (op_valid) begin
            fin <= op_data.fin;
            unique case (op_data.op)
              OP_WORD: begin
                kreg  <= op_data.value;
                state <= S_K1;
              end
              OP_TAIL: begin
                kreg  <= op_data.value;
                state <= S_T;
              end
              default: begin
                acc   <= op_data.value;
                state <= op_data.fin ? S_F1 : S_IDLE;
              end
            endcase
          end
        end
        S_K1: begin
          kreg  <= prod;
          state <= S_K2;
        end
        S_K2: begin
          kreg  <= prod;
          state <= S_H;
        end
        S_H: begin
          acc   <= prod ^ kreg;
          state <= fin ? S_F1 : S_IDLE;
        end
        S_T: begin
          acc   <= prod;
          state <= S_F1;
        end
        S_F1: begin
          acc   <= prod;
          state <= S_F2;
        end
        S_F2: begin
          // wait for the output register to free up
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/murmur2_hash_32.sv
// top level of the 32-bit murmurhash2 block
`timescale 1ns / 1ps
// 32-bit MurmurHash2 over a byte stream. A start item (kind 0) opens a message
// of message_length bytes, hashed from the seed written on the cfg port; data
// items (kind 1) carry one byte each, and the one hash_value item follows the
// last byte, or the start item itself when the length is zero. The front end
// takes one item per cycle while the queue has room, and passes word, tail and
// start operations through a four-entry queue to the back end, which runs them
// on one shared 32x32 multiplier: a start loads the accumulator while idle, a
// full word steps through S_K1, S_K2 and S_H, a tail through S_T, and
// finalization through S_F1 and S_F2, so a steady stream of bytes goes in at
// one per cycle while the queue has room. Bytes outside a message are dropped,
// and a start item in the middle of a message abandons it.
module murmur2_hash_32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [31:0] message_length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value
);
  import mh2_pkg::*;

  logic    push_valid;
  logic    push_ready;
  mh2_op_t push_data;
  logic    pop_valid;
  logic    pop_ready;
  mh2_op_t pop_data;

  mh2_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .message_length (message_length),
    .data_byte      (data_byte),
    .op_valid       (push_valid),
    .op_ready       (push_ready),
    .op_data        (push_data)
  );

  mh2_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mh2_back u_back (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (pop_valid),
    .op_ready   (pop_ready),
    .op_data    (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

endmodule
